// ----- sv/pap_pkg.sv -----
// Shared types, widths, register codes and saturation helpers for the axis projection block.
package pap_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int VERT_W = 32;
    localparam int CFG_W = 32;
    localparam int CFG_IDX_W = 3;
    localparam int PROD_W = 2 * VERT_W;
    localparam int SUM_W = PROD_W + 1;
    localparam int FRAC_W = 16;
    localparam int HALF_W = SUM_W - FRAC_W;
    localparam int XF_W = HALF_W + 1;
    localparam int PROJ_W = 48;
    localparam int QUEUE_DEPTH = 8;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic signed [XF_W-1:0] COORD_MAX =
        (XF_W'(1) <<< (COORD_WIDTH - 1)) - XF_W'(1);
    localparam logic signed [XF_W-1:0] COORD_MIN = -(XF_W'(1) <<< (COORD_WIDTH - 1));
    localparam logic signed [HALF_W-1:0] PROJ_MAX =
        (HALF_W'(1) <<< (PROJ_W - 1)) - HALF_W'(1);
    localparam logic signed [HALF_W-1:0] PROJ_MIN = -(HALF_W'(1) <<< (PROJ_W - 1));

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAT_XX,
        REG_MAT_XY,
        REG_MAT_XT,
        REG_MAT_YX,
        REG_MAT_YY,
        REG_MAT_YT,
        REG_AXIS_X,
        REG_AXIS_Y
    } cfg_index_t;

    typedef struct packed {
        logic signed [PROJ_W-1:0] proj;
        logic                     last;
    } queue_entry_t;

    function automatic logic signed [VERT_W-1:0] sat_coord(input logic signed [XF_W-1:0] v);
        logic signed [XF_W-1:0] r;
        priority if (v > COORD_MAX)
        begin
            r = COORD_MAX;
        end
        else if (v < COORD_MIN)
        begin
            r = COORD_MIN;
        end
        else
        begin
            r = v;
        end
        return r[VERT_W-1:0];
    endfunction

    function automatic logic signed [PROJ_W-1:0] sat_proj(input logic signed [HALF_W-1:0] v);
        logic signed [HALF_W-1:0] r;
        priority if (v > PROJ_MAX)
        begin
            r = PROJ_MAX;
        end
        else if (v < PROJ_MIN)
        begin
            r = PROJ_MIN;
        end
        else
        begin
            r = v;
        end
        return r[PROJ_W-1:0];
    endfunction

endpackage

// ----- sv/pap_front.sv -----
// Front end: configuration registers, request credits and the transform and projection pipeline.
module pap_front
    import pap_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_write,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_W-1:0]         cfg_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [VERT_W-1:0] vertex_x,
    input  logic signed [VERT_W-1:0] vertex_y,
    input  logic                     last_vertex,
    input  logic                     credit_return,
    output logic                     push,
    output queue_entry_t             push_entry
);

    logic signed [CFG_W-1:0] mat_xx_reg, mat_xy_reg, mat_xt_reg;
    logic signed [CFG_W-1:0] mat_yx_reg, mat_yy_reg, mat_yt_reg;
    logic signed [CFG_W-1:0] axis_x_reg, axis_y_reg;

    logic [QCNT_W-1:0] credit_reg, credit_next;
    logic              accept;

    logic [4:0] valid_reg;
    logic [4:0] last_reg;

    logic signed [PROD_W-1:0] p_xx_reg, p_xy_reg, p_yx_reg, p_yy_reg;
    logic signed [HALF_W-1:0] sx_reg, sy_reg;
    logic signed [VERT_W-1:0] px_reg, py_reg;
    logic signed [PROD_W-1:0] dx_reg, dy_reg;
    logic signed [PROJ_W-1:0] proj_reg;

    logic signed [SUM_W-1:0] sum_x, sum_y, sum_d;

    assign in_ready = credit_reg < QCNT_W'(QUEUE_DEPTH);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        credit_next = credit_reg;
        if (accept && !credit_return)
        begin
            credit_next = credit_reg + QCNT_W'(1);
        end
        else if (!accept && credit_return)
        begin
            credit_next = credit_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mat_xx_reg <= CFG_W'(65536);
            mat_xy_reg <= '0;
            mat_xt_reg <= '0;
            mat_yx_reg <= '0;
            mat_yy_reg <= CFG_W'(65536);
            mat_yt_reg <= '0;
            axis_x_reg <= CFG_W'(65536);
            axis_y_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_MAT_XX: mat_xx_reg <= cfg_data;
                REG_MAT_XY: mat_xy_reg <= cfg_data;
                REG_MAT_XT: mat_xt_reg <= cfg_data;
                REG_MAT_YX: mat_yx_reg <= cfg_data;
                REG_MAT_YY: mat_yy_reg <= cfg_data;
                REG_MAT_YT: mat_yt_reg <= cfg_data;
                REG_AXIS_X: axis_x_reg <= cfg_data;
                REG_AXIS_Y: axis_y_reg <= cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            credit_reg <= '0;
            valid_reg  <= '0;
        end
        else
        begin
            credit_reg <= credit_next;
            valid_reg  <= {valid_reg[3:0], accept};
        end
    end

    always_comb
    begin
        sum_x = SUM_W'(p_xx_reg) + SUM_W'(p_xy_reg);
        sum_y = SUM_W'(p_yx_reg) + SUM_W'(p_yy_reg);
        sum_d = SUM_W'(dx_reg) + SUM_W'(dy_reg);
    end

    always_ff @(posedge clk)
    begin
        last_reg <= {last_reg[3:0], last_vertex};
        p_xx_reg <= PROD_W'(mat_xx_reg) * PROD_W'(vertex_x);
        p_xy_reg <= PROD_W'(mat_xy_reg) * PROD_W'(vertex_y);
        p_yx_reg <= PROD_W'(mat_yx_reg) * PROD_W'(vertex_x);
        p_yy_reg <= PROD_W'(mat_yy_reg) * PROD_W'(vertex_y);
        sx_reg   <= sum_x[SUM_W-1:FRAC_W];
        sy_reg   <= sum_y[SUM_W-1:FRAC_W];
        px_reg   <= sat_coord(XF_W'(sx_reg) + XF_W'(mat_xt_reg));
        py_reg   <= sat_coord(XF_W'(sy_reg) + XF_W'(mat_yt_reg));
        dx_reg   <= PROD_W'(axis_x_reg) * PROD_W'(px_reg);
        dy_reg   <= PROD_W'(axis_y_reg) * PROD_W'(py_reg);
        proj_reg <= sat_proj(sum_d[SUM_W-1:FRAC_W]);
    end

    assign push            = valid_reg[4];
    assign push_entry.proj = proj_reg;
    assign push_entry.last = last_reg[4];

    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        credit_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("request credits exceed the queue depth");

endmodule

// ----- sv/pap_queue.sv -----
// Short queue of projected vertices between the front end and the min/max stage.
module pap_queue
    import pap_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  queue_entry_t push_entry,
    input  logic         pop,
    output logic         head_valid,
    output queue_entry_t head_entry
);

    queue_entry_t      store_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    assign head_valid = count_reg != '0;
    assign head_entry = store_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + QCNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg < QCNT_W'(QUEUE_DEPTH)) || pop)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("queue read while empty");

endmodule

// ----- sv/pap_back.sv -----
// Back end: running minimum and maximum per polygon and the result register.
module pap_back
    import pap_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     head_valid,
    input  queue_entry_t             head_entry,
    output logic                     pop,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [PROJ_W-1:0] proj_min,
    output logic signed [PROJ_W-1:0] proj_max
);

    logic signed [PROJ_W-1:0] run_min_reg, run_max_reg;
    logic signed [PROJ_W-1:0] min_next, max_next;
    logic                     first_reg;
    logic                     out_valid_reg;
    logic signed [PROJ_W-1:0] out_min_reg, out_max_reg;

    assign pop = head_valid && (!head_entry.last || !out_valid_reg || out_ready);

    always_comb
    begin
        min_next = run_min_reg;
        max_next = run_max_reg;
        if (first_reg || head_entry.proj < run_min_reg)
        begin
            min_next = head_entry.proj;
        end
        if (first_reg || head_entry.proj > run_max_reg)
        begin
            max_next = head_entry.proj;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_min_reg   <= '0;
            run_max_reg   <= '0;
            first_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (pop)
            begin
                run_min_reg <= min_next;
                run_max_reg <= max_next;
                first_reg   <= head_entry.last;
                if (head_entry.last)
                begin
                    out_valid_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && head_entry.last)
        begin
            out_min_reg <= min_next;
            out_max_reg <= max_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign proj_min  = out_min_reg;
    assign proj_max  = out_max_reg;

    a_result_follows_last: assert property (@(posedge clk) disable iff (!rst_n)
        pop && head_entry.last |=> out_valid_reg && first_reg)
        else $error("closing vertex did not raise a result");

    a_interval_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_min_reg <= out_max_reg)
        else $error("result interval has minimum above maximum");

endmodule

// ----- sv/polygon_axis_projection_core.sv -----
// Top level of the polygon axis projection block.
//
// Each vertex request on the input channel (vertex_x, vertex_y, last_vertex) is
// mapped by the configured 2x3 affine transform and projected onto the configured
// axis. The block keeps the minimum and maximum projection of the current polygon
// and, on the vertex marked last, offers one result (proj_min, proj_max) on the
// output channel. Configuration registers are written through cfg_write, cfg_index
// and cfg_data; the user must write them only while no polygon is in flight, which
// the block itself does not enforce. Throughput is one vertex per cycle while the
// queue has credits left. A result reaches the output register once the closing
// vertex has passed the five front-end stages, the queue and the min/max stage.
// The front end issues requests against credits for the eight-entry queue, so when
// the receiver stalls the queue fills and in_ready falls after at most eight more
// vertices; nothing is dropped. Reset restores the identity transform, the x axis,
// empties the pipeline and the queue, and makes the next vertex start a polygon.
module polygon_axis_projection_core
    import pap_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_write,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_W-1:0]         cfg_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [VERT_W-1:0] vertex_x,
    input  logic signed [VERT_W-1:0] vertex_y,
    input  logic                     last_vertex,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [PROJ_W-1:0] proj_min,
    output logic signed [PROJ_W-1:0] proj_max
);

    logic         push;
    queue_entry_t push_entry;
    logic         pop;
    logic         head_valid;
    queue_entry_t head_entry;

    pap_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .vertex_x      (vertex_x),
        .vertex_y      (vertex_y),
        .last_vertex   (last_vertex),
        .credit_return (pop),
        .push          (push),
        .push_entry    (push_entry)
    );

    pap_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    pap_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .proj_min   (proj_min),
        .proj_max   (proj_max)
    );

endmodule
